// ===== src/gsb_pkg.sv =====
// shared types, constants and helper functions for the genotype segment builder
package gsb_pkg;

  localparam int INDEX_BITS         = 24;
  localparam int LEN_BITS           = 16;
  localparam int MAX_SEGMENT_LENGTH = 65535;
  localparam int MAX_RESULTS        = 6;
  localparam int CNT_BITS           = $clog2(MAX_RESULTS + 1);

  localparam logic [63:0] DIP_ALL  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIP_SCAF = 64'h00AA_00AA_00AA_00AA;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            amb_byte;
    logic [INDEX_BITS-1:0] amb_index;
    logic [LEN_BITS-1:0]   seg_length;
    logic [63:0]           seg_diplotype;
    logic [INDEX_BITS-1:0] seg_index;
    logic                  last;
  } result_t;

  // diplotype mask for an unfold position
  function automatic logic [63:0] pos_mask(input logic [1:0] q);
    logic [63:0] m;
    case (q)
      2'd0:    m = 64'h55AA_55AA_55AA_55AA;
      2'd1:    m = 64'h3333_CCCC_3333_CCCC;
      2'd2:    m = 64'h0F0F_0F0F_F0F0_F0F0;
      default: m = DIP_ALL;
    endcase
    return m;
  endfunction

  // ambiguity byte for an unfold position
  function automatic logic [7:0] pos_byte(input logic [1:0] q);
    logic [7:0] b;
    case (q)
      2'd0:    b = 8'hAA;
      2'd1:    b = 8'hCC;
      2'd2:    b = 8'hF0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic result_t byte_result(input logic [7:0] b,
                                          input logic [INDEX_BITS-1:0] idx);
    result_t r;
    r           = '0;
    r.kind      = KIND_BYTE;
    r.amb_byte  = b;
    r.amb_index = idx;
    return r;
  endfunction

  function automatic result_t seg_result(input logic [LEN_BITS-1:0] len,
                                         input logic [63:0] dip,
                                         input logic [INDEX_BITS-1:0] sidx);
    result_t r;
    r               = '0;
    r.kind          = KIND_SEGMENT;
    r.seg_length    = len;
    r.seg_diplotype = dip;
    r.seg_index     = sidx;
    return r;
  endfunction

endpackage

// ===== src/genotype_segment_builder.sv =====
// top level: variant segmentation, ambiguity bytes and segment records
//
// usage
// - input channel (in_valid / in_ready) takes one variant per transaction:
//   scaffold, het and missing flags, the two phased alleles and a final mark
// - output channel (out_valid / out_ready) gives one result per transaction:
//   an ambiguity byte (kind 0) or a closed segment record (kind 1);
//   last_result marks the final result caused by one variant
// - a variant causes zero to six results, all in stream order
// timing: a variant is held in the input register, its whole result batch is computed
//   combinationally from that register and loaded into a six entry result buffer once
//   the buffer is empty or drains its last entry; its first result then leaves buffer entry 0
// throughput: one variant per cycle while each causes at most one result and
//   out_ready stays high; a variant with more results holds the next one back, since the
//   output port drains the buffer one entry per cycle while out_ready is high
// the input register refills in the cycle the buffer drains its last entry;
//   while the receiver stalls with results still buffered, the registered
//   variant waits and in_ready stays low, so nothing is lost or reordered
// reset: synchronous, clears all segment state, both indices and the buffer;
//   a final variant flushes its segment and also returns to that state
module genotype_segment_builder
  import gsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // variant channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  scaffold_flag,
  input  logic                  het_flag,
  input  logic                  missing_flag,
  input  logic                  allele_first,
  input  logic                  allele_second,
  input  logic                  final_variant,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [7:0]            amb_byte,
  output logic [INDEX_BITS-1:0] amb_index,
  output logic [LEN_BITS-1:0]   seg_length,
  output logic [63:0]           seg_diplotype,
  output logic [INDEX_BITS-1:0] seg_index,
  output logic                  last_result
);

  // input register
  logic in_q_valid;
  logic in_q_scaffold, in_q_het, in_q_missing, in_q_a0, in_q_a1, in_q_final;

  // segment state
  logic [1:0]            unfold_count,    unfold_count_next;
  logic                  scaffold_seen,   scaffold_seen_next;
  logic [LEN_BITS-1:0]   variant_count,   variant_count_next;
  logic [63:0]           diplotype_mask,  diplotype_mask_next;
  logic [1:0]            pending_count,   pending_count_next;
  logic [2:0]            pending_het,     pending_het_next;
  logic [INDEX_BITS-1:0] ambiguous_total, ambiguous_total_next;
  logic [INDEX_BITS-1:0] segment_total,   segment_total_next;

  // result buffer, entry 0 faces the output port
  result_t               res_buf [MAX_RESULTS];
  logic [CNT_BITS-1:0]   res_cnt;

  result_t               batch [MAX_RESULTS];
  logic [CNT_BITS-1:0]   batch_n;

  logic load;
  logic pop;

  assign out_valid = (res_cnt != '0);
  assign pop       = out_valid && out_ready;
  // batch moves into the buffer once the buffer is empty or drains its last entry
  assign load      = in_q_valid && ((res_cnt == '0) || (res_cnt == CNT_BITS'(1) && out_ready));
  assign in_ready  = !in_q_valid || load;

  assign kind          = res_buf[0].kind;
  assign amb_byte      = res_buf[0].amb_byte;
  assign amb_index     = res_buf[0].amb_index;
  assign seg_length    = res_buf[0].seg_length;
  assign seg_diplotype = res_buf[0].seg_diplotype;
  assign seg_index     = res_buf[0].seg_index;
  assign last_result   = res_buf[0].last;

  // whole batch for the registered variant, in one pass
  always_comb begin
    logic                  sca, het, mis, unf, close_now;
    logic [1:0]            uf, pc, q;
    logic                  ss;
    logic [LEN_BITS-1:0]   vc;
    logic [63:0]           dm;
    logic [2:0]            ph;
    logic [INDEX_BITS-1:0] at, st;
    logic [CNT_BITS-1:0]   n;

    sca = in_q_scaffold;
    het = in_q_het & ~sca;
    mis = in_q_missing & ~sca;
    unf = het | mis;

    uf = unfold_count;
    ss = scaffold_seen;
    vc = variant_count;
    dm = diplotype_mask;
    pc = pending_count;
    ph = pending_het;
    at = ambiguous_total;
    st = segment_total;
    q  = '0;
    n  = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      batch[i] = '0;
    end

    // close the open segment before this variant if it would overflow
    close_now = (({1'b0, uf} + 3'(unf) + 3'(ss | sca)) >= 3'd4) ||
                (vc >= LEN_BITS'(MAX_SEGMENT_LENGTH));
    if (close_now) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pc) begin
          batch[n] = byte_result(pos_byte(2'(i) + 2'(ss)),
                                 at - INDEX_BITS'(pc) + INDEX_BITS'(i));
          n = n + CNT_BITS'(1);
        end
      end
      batch[n] = seg_result(vc, dm, st);
      n  = n + CNT_BITS'(1);
      st = st + INDEX_BITS'(1);
      uf = '0;
      ss = 1'b0;
      vc = '0;
      dm = DIP_ALL;
      pc = '0;
      ph = '0;
    end

    if (sca) begin
      if (!ss) begin
        // first scaffold: held bytes and masks move up one position
        dm = DIP_SCAF;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < pc && ph[i]) begin
            dm = dm & pos_mask(2'(i) + 2'd1);
          end
        end
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < pc) begin
            batch[n] = byte_result(pos_byte(2'(i) + 2'd1),
                                   at - INDEX_BITS'(pc) + INDEX_BITS'(i));
            n = n + CNT_BITS'(1);
          end
        end
        pc = '0;
        ph = '0;
        ss = 1'b1;
      end
      batch[n] = byte_result((in_q_a0 ? 8'h55 : 8'h00) | (in_q_a1 ? 8'hAA : 8'h00), at);
      n  = n + CNT_BITS'(1);
      at = at + INDEX_BITS'(1);
    end else if (unf) begin
      q = uf + 2'(ss);
      if (het) begin
        dm = dm & pos_mask(q);
      end
      if (ss) begin
        batch[n] = byte_result(pos_byte(q), at);
        n = n + CNT_BITS'(1);
      end else begin
        if (het) begin
          ph[pc] = 1'b1;
        end
        pc = pc + 2'd1;
      end
      at = at + INDEX_BITS'(1);
      uf = uf + 2'd1;
    end
    vc = vc + LEN_BITS'(1);

    // end of stream: flush and start over at index zero
    if (in_q_final) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pc) begin
          batch[n] = byte_result(pos_byte(2'(i) + 2'(ss)),
                                 at - INDEX_BITS'(pc) + INDEX_BITS'(i));
          n = n + CNT_BITS'(1);
        end
      end
      batch[n] = seg_result(vc, dm, st);
      n  = n + CNT_BITS'(1);
      uf = '0;
      ss = 1'b0;
      vc = '0;
      dm = DIP_ALL;
      pc = '0;
      ph = '0;
      at = '0;
      st = '0;
    end

    if (n != '0) begin
      batch[n - CNT_BITS'(1)].last = 1'b1;
    end

    batch_n              = n;
    unfold_count_next    = uf;
    scaffold_seen_next   = ss;
    variant_count_next   = vc;
    diplotype_mask_next  = dm;
    pending_count_next   = pc;
    pending_het_next     = ph;
    ambiguous_total_next = at;
    segment_total_next   = st;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q_scaffold <= scaffold_flag;
      in_q_het      <= het_flag;
      in_q_missing  <= missing_flag;
      in_q_a0       <= allele_first;
      in_q_a1       <= allele_second;
      in_q_final    <= final_variant;
    end
  end

  // segment state advances with each batch
  always_ff @(posedge clk) begin
    if (rst) begin
      unfold_count    <= '0;
      scaffold_seen   <= 1'b0;
      variant_count   <= '0;
      diplotype_mask  <= DIP_ALL;
      pending_count   <= '0;
      pending_het     <= '0;
      ambiguous_total <= '0;
      segment_total   <= '0;
    end else if (load) begin
      unfold_count    <= unfold_count_next;
      scaffold_seen   <= scaffold_seen_next;
      variant_count   <= variant_count_next;
      diplotype_mask  <= diplotype_mask_next;
      pending_count   <= pending_count_next;
      pending_het     <= pending_het_next;
      ambiguous_total <= ambiguous_total_next;
      segment_total   <= segment_total_next;
    end
  end

  // result buffer: parallel load, shift out one entry per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (load) begin
      res_cnt <= batch_n;
    end else if (pop) begin
      res_cnt <= res_cnt - CNT_BITS'(1);
    end
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= batch[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i + 1];
      end
    end
  end

  // buffer never holds more than one batch
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_BITS'(MAX_RESULTS))
    else $error("result buffer count out of range");

  // the final entry of a batch carries the last mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    pop && res_cnt == CNT_BITS'(1) |-> last_result)
    else $error("batch drained without last mark");

  // unfold positions plus the scaffold slot never exceed three
  a_unfold_limit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, unfold_count} + 3'(scaffold_seen)) <= 3'd3)
    else $error("unfold count overflow");

  // bytes are only held while the segment has no scaffold
  a_pending_no_scaf: assert property (@(posedge clk) disable iff (rst)
    pending_count != '0 |-> !scaffold_seen)
    else $error("pending bytes with scaffold present");

  // a final variant returns the stream to its start
  a_final_restart: assert property (@(posedge clk) disable iff (rst)
    load && in_q_final |=> (ambiguous_total == '0 && segment_total == '0 &&
                            variant_count == '0 && pending_count == '0))
    else $error("state not cleared after final variant");

endmodule
